>>> sv/bar_ring_upsert_core_assert.svh
// assertion macros shared by the bar ring checker
`ifndef BAR_RING_UPSERT_CORE_ASSERT_SVH
`define BAR_RING_UPSERT_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BRU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bar ring check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BRU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bar ring check failed");

`endif

>>> sv/bru_pkg.sv
// shared types and constants of the bar ring
package bru_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int COUNT_W    = $clog2(RING_DEPTH + 1);

    localparam int TIME_W   = 40;
    localparam int PRICE_W  = 32;
    localparam int VOLUME_W = 48;
    localparam int IVAL_W   = 23;

    localparam logic [SLOT_W-1:0]  LAST_SLOT      = SLOT_W'(RING_DEPTH - 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT     = COUNT_W'(RING_DEPTH);
    localparam logic [IVAL_W-1:0]  INTRADAY_LIMIT = IVAL_W'(86400);
    localparam logic [IVAL_W-1:0]  IVAL_RESET     = IVAL_W'(60);

    typedef struct packed {
        logic [TIME_W-1:0]   bar_time;
        logic [PRICE_W-1:0]  bar_open;
        logic [PRICE_W-1:0]  bar_high;
        logic [PRICE_W-1:0]  bar_low;
        logic [PRICE_W-1:0]  bar_close;
        logic [VOLUME_W-1:0] bar_volume;
        logic                bar_done;
    } bar_entry_t;

    localparam int ENTRY_W = $bits(bar_entry_t);

    typedef struct packed {
        logic hit;
        logic older;
        logic same;
    } cmp_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DECIDE,
        ST_FINISH
    } state_t;

endpackage

>>> sv/bar_ring_upsert_core.sv
// top level of the bar ring: handshakes, walk sequencer and ring pointers
//
// input channel: in_valid/in_ready carry one bar word (time, open, high, low,
//   close, volume, done flag); in_ready is high only while the block is idle
// output channel: out_valid/out_ready carry one result word per bar
//   (changed, latest_close, held_count), held in an output register
// config: cfg_wr_en/cfg_wr_data write the bar interval at once, no wait
// the bars sit in one ram of 1024 entries with a registered read;
//   the walk back from the newest bar reads one entry per cycle
// result: a bar that matches an entry goes from the walk straight to the
//   finish state; a bar stopped by an older entry, or that runs out of held
//   bars, and a bar into an empty ring pass through the decide state first
// pacing: one bar at a time, a new bar is taken in the cycle after the
//   result word is loaded
// reset: ring empty, newest pointer on the last slot, interval 60 s; the ram
//   needs no clearing pass since only written entries are ever read
// a stalled receiver holds the finished word; the next bar may already be
//   taken and walked, its result waits until the output register is free
module bar_ring_upsert_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bru_pkg::IVAL_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bru_pkg::TIME_W-1:0]    bar_time,
    input  logic [bru_pkg::PRICE_W-1:0]   bar_open,
    input  logic [bru_pkg::PRICE_W-1:0]   bar_high,
    input  logic [bru_pkg::PRICE_W-1:0]   bar_low,
    input  logic [bru_pkg::PRICE_W-1:0]   bar_close,
    input  logic [bru_pkg::VOLUME_W-1:0]  bar_volume,
    input  logic                          bar_done,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          changed,
    output logic [bru_pkg::PRICE_W-1:0]   latest_close,
    output logic [bru_pkg::COUNT_W-1:0]   held_count
);
    import bru_pkg::*;

    state_t state_reg, state_next;

    bar_entry_t cur_reg;           // bar word being worked on
    logic [IVAL_W-1:0] interval_reg;

    logic [SLOT_W-1:0]  walk_slot_reg, walk_slot_next;
    logic [COUNT_W-1:0] age_reg, age_next;
    logic [SLOT_W-1:0]  newest_slot_reg, newest_slot_next;
    logic [COUNT_W-1:0] fill_reg, fill_next;
    logic [TIME_W-1:0]  newest_time_reg, newest_time_next;
    logic [PRICE_W-1:0] newest_close_reg, newest_close_next;
    logic               chg_reg, chg_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_changed_reg;
    logic [PRICE_W-1:0] out_close_reg;
    logic [COUNT_W-1:0] out_count_reg;

    // ram port
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    bar_entry_t        wr_data;
    logic [ENTRY_W-1:0] rd_data;
    bar_entry_t        stored;

    cmp_res_t   cmp_res;
    bar_entry_t merged;

    logic               accept;
    logic               out_free;
    logic               walk_on;
    logic [COUNT_W-1:0] age_inc;
    logic [SLOT_W-1:0]  prev_slot;
    logic [SLOT_W-1:0]  append_slot;
    logic [TIME_W-1:0]  gap;
    logic               drop;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign stored = bar_entry_t'(rd_data);

    bru_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bru_cmp u_cmp (
        .stored   (stored),
        .incoming (cur_reg),
        .res      (cmp_res),
        .merged   (merged)
    );

    // ring arithmetic, wrapping at any depth
    assign age_inc     = age_reg + COUNT_W'(1);
    assign prev_slot   = (walk_slot_reg == '0) ? LAST_SLOT : walk_slot_reg - SLOT_W'(1);
    assign append_slot = (newest_slot_reg == LAST_SLOT) ? '0 : newest_slot_reg + SLOT_W'(1);

    // keep walking while neither a match nor an older bar turned up and unread held bars remain
    assign walk_on = !cmp_res.hit && !cmp_res.older && (age_inc < fill_reg);

    // no-match drop test against the newest held bar
    assign gap  = cur_reg.bar_time - newest_time_reg;
    assign drop = (fill_reg != '0)
               && ((cur_reg.bar_time <= newest_time_reg)
                   || ((interval_reg < INTRADAY_LIMIT)
                       && (gap < TIME_W'(interval_reg))));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (fill_reg != '0) ? ST_WALK : ST_DECIDE;
                end
            end
            ST_WALK:
            begin
                if (cmp_res.hit)
                begin
                    state_next = ST_FINISH;
                end
                else if (!walk_on)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs: handshake and ram port
    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = newest_slot_reg;
        wr_en    = 1'b0;
        wr_addr  = walk_slot_reg;
        wr_data  = merged;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_en    = in_valid;
            end
            ST_WALK:
            begin
                rd_en   = walk_on;
                rd_addr = prev_slot;
                wr_en   = cmp_res.hit;
            end
            ST_DECIDE:
            begin
                wr_en   = !drop;
                wr_addr = append_slot;
                wr_data = cur_reg;
            end
            ST_FINISH:
            begin
                in_ready = 1'b0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // pointers, newest-bar shadow and result
    always_comb
    begin
        walk_slot_next    = walk_slot_reg;
        age_next          = age_reg;
        newest_slot_next  = newest_slot_reg;
        fill_next         = fill_reg;
        newest_time_next  = newest_time_reg;
        newest_close_next = newest_close_reg;
        chg_next          = chg_reg;
        out_valid_next    = out_valid_reg && !out_ready;

        if (accept)
        begin
            walk_slot_next = newest_slot_reg;
            age_next       = '0;
        end

        if (state_reg == ST_WALK)
        begin
            if (cmp_res.hit)
            begin
                chg_next = !cmp_res.same;
                if (walk_slot_reg == newest_slot_reg)
                begin
                    newest_close_next = cur_reg.bar_close;
                end
            end
            else if (walk_on)
            begin
                walk_slot_next = prev_slot;
                age_next       = age_inc;
            end
        end

        if (state_reg == ST_DECIDE)
        begin
            chg_next = !drop;
            if (!drop)
            begin
                newest_slot_next  = append_slot;
                newest_time_next  = cur_reg.bar_time;
                newest_close_next = cur_reg.bar_close;
                if (fill_reg != FULL_COUNT)
                begin
                    fill_next = fill_reg + COUNT_W'(1);
                end
            end
        end

        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            interval_reg     <= IVAL_RESET;
            walk_slot_reg    <= '0;
            age_reg          <= '0;
            newest_slot_reg  <= LAST_SLOT;
            fill_reg         <= '0;
            newest_time_reg  <= '0;
            newest_close_reg <= '0;
            chg_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            walk_slot_reg    <= walk_slot_next;
            age_reg          <= age_next;
            newest_slot_reg  <= newest_slot_next;
            fill_reg         <= fill_next;
            newest_time_reg  <= newest_time_next;
            newest_close_reg <= newest_close_next;
            chg_reg          <= chg_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_wr_en)
            begin
                interval_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg.bar_time   <= bar_time;
            cur_reg.bar_open   <= bar_open;
            cur_reg.bar_high   <= bar_high;
            cur_reg.bar_low    <= bar_low;
            cur_reg.bar_close  <= bar_close;
            cur_reg.bar_volume <= bar_volume;
            cur_reg.bar_done   <= bar_done;
        end
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_changed_reg <= chg_reg;
            out_close_reg   <= newest_close_reg;   // zero while the ring is empty
            out_count_reg   <= fill_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign changed      = out_changed_reg;
    assign latest_close = out_close_reg;
    assign held_count   = out_count_reg;

endmodule

>>> sv/bru_ram.sv
// generic simple dual-port ram with registered read
module bru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/bru_cmp.sv
// compares a stored bar with the incoming one and builds the merged entry
module bru_cmp (
    input  bru_pkg::bar_entry_t stored,
    input  bru_pkg::bar_entry_t incoming,
    output bru_pkg::cmp_res_t   res,
    output bru_pkg::bar_entry_t merged
);
    import bru_pkg::*;

    logic [VOLUME_W-1:0] new_volume;

    // zero volume means unknown: keep what is stored
    assign new_volume = (incoming.bar_volume == '0) ? stored.bar_volume : incoming.bar_volume;

    always_comb
    begin
        merged            = incoming;
        merged.bar_volume = new_volume;
    end

    assign res.hit   = (stored.bar_time == incoming.bar_time);
    assign res.older = (stored.bar_time < incoming.bar_time);
    assign res.same  = (stored.bar_open   == incoming.bar_open)
                    && (stored.bar_high   == incoming.bar_high)
                    && (stored.bar_low    == incoming.bar_low)
                    && (stored.bar_close  == incoming.bar_close)
                    && (stored.bar_volume == new_volume)
                    && (stored.bar_done   == incoming.bar_done);

endmodule

>>> sv/bru_chk.sv
// port-level checker for the bar ring, bound to the top level
`include "bar_ring_upsert_core_assert.svh"

module bru_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        changed,
    input logic [bru_pkg::PRICE_W-1:0] latest_close,
    input logic [bru_pkg::COUNT_W-1:0] held_count
);
    import bru_pkg::*;

    // the ring never reports more bars than it has slots
    `BRU_ASSERT_IMP(a_count_bound, out_valid, held_count <= FULL_COUNT)

    // an empty ring cannot have been modified and has no close
    `BRU_ASSERT_IMP(a_empty_quiet, out_valid && (held_count == '0), !changed && (latest_close == '0))

    // a taken bar keeps the block busy for at least the next cycle
    `BRU_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // a stalled result word holds
    `BRU_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(held_count) && $stable(latest_close) && $stable(changed))

endmodule

bind bar_ring_upsert_core bru_chk u_bru_chk (.*);

>>> sim/testbench.sv
// self-checking testbench of the bar ring upsert core with its own ring predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bru_pkg::*;

    // one result word as the block presents it
    typedef struct packed {
        logic                changed;
        logic [PRICE_W-1:0]  latest_close;
        logic [COUNT_W-1:0]  held_count;
    } ring_word_t;

    // how a random bar relates to what the ring holds when it arrives
    typedef enum int {
        KIND_APPEND,   // newer than the newest by at least one interval
        KIND_NEWEST,   // same time as the newest bar, fresh content
        KIND_RECENT,   // same time as one of the few newest bars
        KIND_REPEAT,   // the previous bar sent again, maybe with volume unknown
        KIND_CLOSE,    // newer than the newest but inside one interval
        KIND_OLDER,    // a little older than the newest, usually no match
        KIND_DEEP,     // same time as a bar anywhere in the ring, long walk
        KIND_NOISE     // any time up to the newest, may walk the whole ring
    } bar_kind_e;

    // receiver behaviour between long hold-offs
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_LIGHT
    } rx_mode_e;

    localparam int STALL_LIMIT    = 20000;
    localparam int HOLD_CYCLES    = 150;
    localparam int FIRST_HOLD_AT  = 300;
    localparam int SECOND_HOLD_AT = 1100;
    localparam int PHASE_ITEMS    = 230;
    localparam int MAX_PRINTS     = 100;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [IVAL_W-1:0]    cfg_wr_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [TIME_W-1:0]    bar_time = '0;
    logic [PRICE_W-1:0]   bar_open = '0;
    logic [PRICE_W-1:0]   bar_high = '0;
    logic [PRICE_W-1:0]   bar_low = '0;
    logic [PRICE_W-1:0]   bar_close = '0;
    logic [VOLUME_W-1:0]  bar_volume = '0;
    logic                 bar_done = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 changed;
    logic [PRICE_W-1:0]   latest_close;
    logic [COUNT_W-1:0]   held_count;

    bar_ring_upsert_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .bar_time     (bar_time),
        .bar_open     (bar_open),
        .bar_high     (bar_high),
        .bar_low      (bar_low),
        .bar_close    (bar_close),
        .bar_volume   (bar_volume),
        .bar_done     (bar_done),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .changed      (changed),
        .latest_close (latest_close),
        .held_count   (held_count)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // ring predictor: its own copy of the stores, pointers and interval
    // ------------------------------------------------------------------
    bar_entry_t          ring_bars [RING_DEPTH];
    int unsigned         head_slot = RING_DEPTH - 1;   // first append lands in slot 0
    int unsigned         held_bars = 0;                // saturates at the ring depth
    logic [IVAL_W-1:0]   gap_ival = IVAL_RESET;

    // tallies for the closing summary
    int unsigned n_appended = 0;
    int unsigned n_overwrote = 0;
    int unsigned n_updated = 0;
    int unsigned n_unchanged = 0;
    int unsigned n_dropped = 0;
    int unsigned deepest_match = 0;

    // applies one bar to the predicted ring and returns the word it should cause
    function automatic ring_word_t upsert_bar(bar_entry_t b);
        ring_word_t          r;
        bar_entry_t          merged;
        int unsigned         age;
        int unsigned         idx;
        logic                found;
        logic                stop;
        logic                refuse;
        logic [TIME_W-1:0]   newest_t;
        r.changed = 1'b0;
        found = 1'b0;
        stop = 1'b0;
        // walk back from the newest bar, giving up at the first older one
        for (age = 0; age < held_bars && !stop; age++) begin
            idx = (head_slot + RING_DEPTH - age) % RING_DEPTH;
            if (ring_bars[idx].bar_time == b.bar_time) begin
                merged = b;
                // unknown volume keeps what is stored
                if (b.bar_volume == '0)
                    merged.bar_volume = ring_bars[idx].bar_volume;
                r.changed = (merged != ring_bars[idx]);
                ring_bars[idx] = merged;
                found = 1'b1;
                stop = 1'b1;
                n_updated++;
                if (!r.changed)
                    n_unchanged++;
                if (age > deepest_match)
                    deepest_match = age;
            end else if (ring_bars[idx].bar_time < b.bar_time) begin
                stop = 1'b1;
            end
        end
        if (!found) begin
            refuse = 1'b0;
            if (held_bars > 0) begin
                newest_t = ring_bars[head_slot].bar_time;
                if (b.bar_time <= newest_t)
                    refuse = 1'b1;
                else if (gap_ival < INTRADAY_LIMIT && (b.bar_time - newest_t) < gap_ival)
                    refuse = 1'b1;   // intraday bar too close to the newest one
            end
            if (refuse) begin
                n_dropped++;
            end else begin
                if (held_bars < RING_DEPTH)
                    held_bars++;
                else
                    n_overwrote++;
                head_slot = (head_slot + 1) % RING_DEPTH;
                ring_bars[head_slot] = b;
                r.changed = 1'b1;
                n_appended++;
            end
        end
        r.latest_close = (held_bars > 0) ? ring_bars[head_slot].bar_close : '0;
        r.held_count = COUNT_W'(held_bars);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // bookkeeping shared by the driver, the monitor and the stimulus
    // ------------------------------------------------------------------
    bar_entry_t   bar_queue [$];        // bars waiting for the driver
    ring_word_t   pending_results [$];  // predicted words not yet seen
    logic         bar_accepted = 1'b0;  // a word was taken at the last rising edge
    int unsigned  bars_taken = 0;
    int unsigned  results_seen = 0;
    int unsigned  mismatches = 0;

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at result %0d, %s: got %0h, expected %0h",
                     results_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // monitor and predictor: sample at the rising edge, check the oldest
    // expectation first, then predict for a bar taken at the same edge
    // ------------------------------------------------------------------
    always @(posedge clk) begin : check_and_predict
        ring_word_t  got;
        ring_word_t  want;
        bar_entry_t  seen;
        if (rst_n) begin
            if (cfg_wr_en)
                gap_ival = cfg_wr_data;
            if (out_valid && out_ready) begin
                got.changed = changed;
                got.latest_close = latest_close;
                got.held_count = held_count;
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch("result word with nothing expected", 64'(got), 64'(0));
                end else begin
                    want = pending_results.pop_front();
                    if (got.changed !== want.changed)
                        report_mismatch("changed", 64'(got.changed), 64'(want.changed));
                    if (got.latest_close !== want.latest_close)
                        report_mismatch("latest_close", 64'(got.latest_close),
                                        64'(want.latest_close));
                    if (got.held_count !== want.held_count)
                        report_mismatch("held_count", 64'(got.held_count),
                                        64'(want.held_count));
                end
            end
            if (in_valid && in_ready) begin
                seen.bar_time = bar_time;
                seen.bar_open = bar_open;
                seen.bar_high = bar_high;
                seen.bar_low = bar_low;
                seen.bar_close = bar_close;
                seen.bar_volume = bar_volume;
                seen.bar_done = bar_done;
                pending_results = {pending_results, upsert_bar(seen)};
                bars_taken++;
            end
            bar_accepted <= in_valid && in_ready;
        end
    end

    // ------------------------------------------------------------------
    // driver: bursts of random length with random gaps, some long bursts
    // with no gap at all; a word is held until it has been taken
    // ------------------------------------------------------------------
    int unsigned send_gap = 0;
    int unsigned send_burst = 0;

    always @(negedge clk) begin : drive_bars
        bar_entry_t nxt;
        if (rst_n && !(in_valid && !bar_accepted)) begin
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (bar_queue.size() != 0) begin
                nxt = bar_queue.pop_front();
                bar_time <= nxt.bar_time;
                bar_open <= nxt.bar_open;
                bar_high <= nxt.bar_high;
                bar_low <= nxt.bar_low;
                bar_close <= nxt.bar_close;
                bar_volume <= nxt.bar_volume;
                bar_done <= nxt.bar_done;
                in_valid <= 1'b1;
                if (send_burst > 0)
                    send_burst--;
                if (send_burst == 0) begin
                    send_gap = $urandom_range(1, 6);
                    send_burst = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                            : $urandom_range(1, 12);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: a changing stall pattern, plus two long hold-offs during
    // which the sender keeps offering so the block backs up
    // ------------------------------------------------------------------
    rx_mode_e    rx_mode = RX_OPEN;
    int unsigned rx_mode_left = 0;
    int unsigned hold_left = 0;
    int unsigned holds_done = 0;

    always @(negedge clk) begin : drive_ready
        logic rdy;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if ((holds_done == 0 && results_seen >= FIRST_HOLD_AT) ||
                     (holds_done == 1 && results_seen >= SECOND_HOLD_AT)) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
            rdy = 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = rx_mode_e'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(16, 160);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_OPEN:   rdy = 1'b1;
                RX_COIN:   rdy = 1'($urandom_range(0, 1));
                RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                default:   rdy = ($urandom_range(0, 7) != 0);
            endcase
        end
        out_ready <= rdy;
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any word moving on either channel
    // ------------------------------------------------------------------
    int unsigned idle_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL bar_ring_upsert_core");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus planning: the times of the bars the ring will hold, kept
    // only to aim updates, gaps and walks at the right places
    // ------------------------------------------------------------------
    logic [TIME_W-1:0]  planned_times [$];
    logic [IVAL_W-1:0]  cur_ival = IVAL_RESET;
    bar_entry_t         last_bar;
    logic               repeat_safe = 1'b0;   // cleared when the interval changes

    function automatic logic [PRICE_W-1:0] pick_price();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic bar_entry_t rand_bar(logic [TIME_W-1:0] t);
        bar_entry_t b;
        b.bar_time = t;
        b.bar_open = pick_price();
        b.bar_high = pick_price();
        b.bar_low = pick_price();
        b.bar_close = pick_price();
        case ($urandom_range(0, 11))
            0, 1:    b.bar_volume = '0;   // volume unknown
            2:       b.bar_volume = '1;
            default: b.bar_volume = VOLUME_W'({$urandom, $urandom});
        endcase
        b.bar_done = 1'($urandom_range(0, 1));
        return b;
    endfunction

    task automatic queue_bar(bar_entry_t b, bit appends);
        bar_queue = {bar_queue, b};
        last_bar = b;
        repeat_safe = 1'b1;
        if (appends) begin
            planned_times = {planned_times, b.bar_time};
            if (planned_times.size() > RING_DEPTH)
                void'(planned_times.pop_front());
        end
    endtask

    task automatic plan_random_bar();
        bar_kind_e          kind;
        int unsigned        pick;
        int unsigned        age;
        longint unsigned    delta;
        logic [TIME_W-1:0]  newest;
        bar_entry_t         b;
        bit                 appends;
        pick = $urandom_range(0, 99);
        if (planned_times.size() == 0) kind = KIND_APPEND;
        else if (pick < 66)            kind = KIND_APPEND;
        else if (pick < 76)            kind = KIND_NEWEST;
        else if (pick < 81)            kind = KIND_RECENT;
        else if (pick < 86)            kind = KIND_REPEAT;
        else if (pick < 91)            kind = KIND_CLOSE;
        else if (pick < 95)            kind = KIND_OLDER;
        else if (pick < 97)            kind = KIND_DEEP;
        else                           kind = KIND_NOISE;
        if (kind == KIND_REPEAT && !repeat_safe)
            kind = KIND_NEWEST;
        newest = (planned_times.size() != 0) ? planned_times[$] : '0;
        appends = 1'b0;
        case (kind)
            KIND_APPEND: begin
                delta = longint'(cur_ival == 0 ? 1 : cur_ival) * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0)
                    delta += $urandom_range(1, 40);
                b = rand_bar(newest + TIME_W'(delta));
                appends = 1'b1;
            end
            KIND_NEWEST:
                b = rand_bar(newest);
            KIND_RECENT: begin
                age = (planned_times.size() < 2) ? 0 :
                      $urandom_range(1, (planned_times.size() > 8) ? 7 : planned_times.size() - 1);
                b = rand_bar(planned_times[$ - age]);
            end
            KIND_REPEAT: begin
                b = last_bar;
                if ($urandom_range(0, 2) == 0)
                    b.bar_volume = '0;
            end
            KIND_CLOSE: begin
                delta = (cur_ival > 1) ? $urandom_range(1, cur_ival - 1) : 1;
                appends = (cur_ival == 0 || cur_ival >= INTRADAY_LIMIT || delta >= cur_ival);
                b = rand_bar(newest + TIME_W'(delta));
            end
            KIND_OLDER:
                b = rand_bar((newest > 8) ? newest - $urandom_range(1, 8) : newest);
            KIND_DEEP: begin
                age = $urandom_range(0, planned_times.size() - 1);
                b = rand_bar(planned_times[$ - age]);
            end
            default:
                b = rand_bar(TIME_W'({$urandom, $urandom} % (longint'(newest) + 1)));
        endcase
        queue_bar(b, appends);
    endtask

    // nothing queued, nothing expected, nothing on the wire, then a settling
    // wait on the falling edge
    task automatic wait_idle();
        while (bar_queue.size() != 0 || pending_results.size() != 0 || in_valid)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_interval(logic [IVAL_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cur_ival = value;
        repeat_safe = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned  phase_ival [8];
        int unsigned  phase;
        int unsigned  n;
        bar_entry_t   b;
        // reset value first, then the extremes, the intraday boundary and an
        // out-of-range zero
        phase_ival = '{60, 1, 0, 86399, 86400, 7776000, 8388607, 300};

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed opening under the reset interval of 60 s
        b = '0;
        queue_bar(b, 1);                  // empty ring, all-zero bar appended
        queue_bar(b, 0);                  // identical bar, match without change
        b.bar_open = '1;
        b.bar_high = '1;
        b.bar_low = '1;
        b.bar_close = '1;
        b.bar_volume = '1;
        b.bar_done = 1'b1;
        queue_bar(b, 0);                  // every field but the time at its top
        b.bar_volume = '0;
        queue_bar(b, 0);                  // unknown volume keeps the stored one
        b.bar_done = 1'b0;
        queue_bar(b, 0);                  // only the complete flag differs
        queue_bar(rand_bar(30), 0);       // inside the interval, dropped
        queue_bar(rand_bar(59), 0);       // one second short of the interval
        queue_bar(rand_bar(60), 1);       // exactly one interval later
        queue_bar(rand_bar(61), 0);
        queue_bar(rand_bar(50), 0);       // older than newest, walk stops at time 0
        queue_bar(rand_bar(0), 0);        // match one bar back
        queue_bar(rand_bar(120), 1);
        queue_bar(rand_bar(180), 1);
        queue_bar(rand_bar(0), 0);        // match three bars back

        for (phase = 0; phase < 8; phase++) begin
            if (phase != 0) begin
                // sender pauses until every word is back before the register moves
                wait_idle();
                write_interval(IVAL_W'(phase_ival[phase]));
            end
            for (n = 0; n < PHASE_ITEMS; n++)
                plan_random_bar();
        end

        // top of the time range, then the same bar again
        b = rand_bar('1);
        queue_bar(b, 1);
        queue_bar(b, 0);
        b.bar_volume = '0;
        b.bar_close = ~b.bar_close;
        queue_bar(b, 0);

        wait_idle();
        repeat (20) @(negedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 64'(pending_results.size()), 64'(0));

        $display("covered %0d bars and %0d result words over 8 interval settings, %0d long holds",
                 bars_taken, results_seen, holds_done);
        $write("appends %0d (oldest overwritten %0d), updates %0d (%0d unchanged), ",
               n_appended, n_overwrote, n_updated, n_unchanged);
        $display("drops %0d, deepest match %0d back", n_dropped, deepest_match);
        if (mismatches == 0)
            $display("PASS bar_ring_upsert_core");
        else
            $display("FAIL bar_ring_upsert_core");
        $finish;
    end

endmodule
